[hw/rtl/hdr_pixel_tonemap_to_unorm8_top_assert.svh]
// Assertion macros for the HDR pixel tonemap block.
// Used by hdr_pixel_tonemap_to_unorm8_top; no other dependencies.
`ifndef HDR_PIXEL_TONEMAP_TO_UNORM8_TOP_ASSERT_SVH
`define HDR_PIXEL_TONEMAP_TO_UNORM8_TOP_ASSERT_SVH
`ifndef SYNTH
// implication checked on every rising clock edge outside reset
`define HPT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// implication with the consequent checked in the next cycle
`define HPT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define HPT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define HPT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/hpt_pkg.sv]
// Shared types, codes and helper functions of the HDR pixel tonemap block.
// No dependencies.
package hpt_pkg;

    localparam logic [1:0] MODE_HALF_TONE  = 2'd0;
    localparam logic [1:0] MODE_FLOAT_TONE = 2'd1;
    localparam logic [1:0] MODE_HALF_WIDEN = 2'd2;

    localparam int unsigned NUM_LANES = 4;
    localparam int unsigned CH_W      = 32;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [CH_W-1:0] result;
    } lane_stat_t;

    // exact binary16 -> binary32 widening
    function automatic logic [31:0] hpt_widen_half(logic [15:0] h);
        logic       sgn;
        logic [4:0] ex;
        logic [9:0] man;
        logic [3:0] k;
        logic [9:0] nm;
        logic [7:0] e32;
        sgn = h[15];
        ex  = h[14:10];
        man = h[9:0];
        k   = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (man[i])
            begin
                k = 4'(10 - i);
            end
        end
        nm  = man << k;
        e32 = 8'd113 - {4'd0, k};
        if (ex == 5'd0 && man == 10'd0)
        begin
            hpt_widen_half = {sgn, 31'd0};
        end
        else if (ex == 5'd0)
        begin
            hpt_widen_half = {sgn, e32, nm, 13'd0};
        end
        else if (ex == 5'h1F)
        begin
            hpt_widen_half = {sgn, 8'hFF, man, 13'd0};
        end
        else
        begin
            hpt_widen_half = {sgn, 8'({3'd0, ex} + 8'd112), man, 13'd0};
        end
    endfunction

endpackage

[hw/rtl/hpt_lane.sv]
// One channel lane: decode, 1+v add, restoring divider, UNORM8 quantize, or half widening.
// Depends on hpt_pkg.
module hpt_lane
    import hpt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            take,
    input  logic [1:0]      mode,
    input  logic            is_alpha,
    input  logic [CH_W-1:0] raw,
    output lane_stat_t      stat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_RND  = 3'd3;
    localparam logic [2:0] S_QMUL = 3'd4;
    localparam logic [2:0] S_QSUM = 3'd5;
    localparam logic [2:0] S_QFIN = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic [7:0] EXP_ONE  = 8'd127;
    localparam logic [7:0] EXP_TINY = 8'd93;   // below 2^-34 the result is 0
    localparam logic [4:0] DIV_LAST = 5'd25;

    logic [2:0]  state_reg, state_next;
    logic [31:0] res_reg, res_next;
    logic [23:0] man_a_reg, man_a_next;
    logic [7:0]  exp_a_reg, exp_a_next;
    logic [23:0] man_b_reg, man_b_next;
    logic [7:0]  exp_b_reg, exp_b_next;
    logic [24:0] rem_reg, rem_next;
    logic [25:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [32:0] xr_reg, xr_next;
    logic [34:0] sum_reg, sum_next;

    // decode
    logic [31:0] vbits;
    logic        v_sgn;
    logic [7:0]  v_exp;
    logic [22:0] v_frc;

    // 1 + v
    logic        big_v;
    logic [23:0] big_m, small_m;
    logic [7:0]  ebig, dfull, esum;
    logic [4:0]  dsh;
    logic [26:0] sm27, shd, lmask, nm;
    logic        a_stk, a_g, a_s, a_inc;
    logic [27:0] sum28;
    logic [24:0] a_m25;

    // divider step
    logic [24:0] d_diff;
    logic        d_bit;
    logic [24:0] d_rem;

    // quotient rounding
    logic signed [9:0] ediff, eq;
    logic [23:0] q_man;
    logic        q_g, q_s, q_inc;
    logic [24:0] q_m25;

    // quantize
    logic [31:0] x_prod;
    logic [23:0] x_keep;
    logic        x_g, x_s, x_inc;
    logic [24:0] x_m25;
    logic [34:0] pf, pf_mask;
    logic [5:0]  rsh;
    logic [5:0]  lead, lb;
    logic [34:0] f_low, f_rnd;
    logic        f_g, f_s, f_inc;

    always_comb
    begin
        vbits = (mode == MODE_HALF_TONE) ? hpt_widen_half(raw[15:0]) : raw;
        v_sgn = vbits[31];
        v_exp = vbits[30:23];
        v_frc = vbits[22:0];
    end

    // add 1.0 to v, round to nearest even
    always_comb
    begin
        big_v   = exp_a_reg >= EXP_ONE;
        big_m   = big_v ? man_a_reg : 24'h800000;
        small_m = big_v ? 24'h800000 : man_a_reg;
        ebig    = big_v ? exp_a_reg : EXP_ONE;
        dfull   = big_v ? (exp_a_reg - EXP_ONE) : (EXP_ONE - exp_a_reg);
        dsh     = (dfull > 8'd27) ? 5'd27 : dfull[4:0];
        sm27    = {small_m, 3'd0};
        shd     = sm27 >> dsh;
        lmask   = ~(27'h7FFFFFF << dsh);
        a_stk   = |(sm27 & lmask);
        sum28   = {1'b0, big_m, 3'd0} + {1'b0, shd[26:1], shd[0] | a_stk};
        if (sum28[27])
        begin
            nm   = {sum28[27:2], sum28[1] | sum28[0]};
            esum = ebig + 8'd1;
        end
        else
        begin
            nm   = sum28[26:0];
            esum = ebig;
        end
        a_g   = nm[2];
        a_s   = |nm[1:0];
        a_inc = a_g & (a_s | nm[3]);
        a_m25 = {1'b0, nm[26:3]} + {24'd0, a_inc};
    end

    always_comb
    begin
        d_diff = rem_reg - {1'b0, man_b_reg};
        d_bit  = rem_reg >= {1'b0, man_b_reg};
        d_rem  = d_bit ? d_diff : rem_reg;
    end

    always_comb
    begin
        ediff = $signed({2'd0, exp_a_reg}) - $signed({2'd0, exp_b_reg}) + 10'sd126;
        if (quo_reg[25])
        begin
            q_man = quo_reg[25:2];
            q_g   = quo_reg[1];
            q_s   = quo_reg[0] | (rem_reg != 25'd0);
            eq    = ediff + 10'sd1;
        end
        else
        begin
            q_man = quo_reg[24:1];
            q_g   = quo_reg[0];
            q_s   = rem_reg != 25'd0;
            eq    = ediff;
        end
        q_inc = q_g & (q_s | q_man[0]);
        q_m25 = {1'b0, q_man} + {24'd0, q_inc};
    end

    // t*255 rounded to 24 significant bits, held as an integer
    always_comb
    begin
        x_prod = man_a_reg * 8'd255;
        if (x_prod[31])
        begin
            x_keep = x_prod[31:8];
            x_g    = x_prod[7];
            x_s    = |x_prod[6:0];
        end
        else
        begin
            x_keep = x_prod[30:7];
            x_g    = x_prod[6];
            x_s    = |x_prod[5:0];
        end
        x_inc = x_g & (x_s | x_keep[0]);
        x_m25 = {1'b0, x_keep} + {24'd0, x_inc};
    end

    // p in fixed point with 26 fraction bits, sticky in bit 0
    always_comb
    begin
        rsh     = 6'd0;
        pf_mask = '0;
        if (exp_a_reg >= 8'd124)
        begin
            pf = {2'd0, xr_reg} << 2'(exp_a_reg - 8'd124);
        end
        else
        begin
            rsh     = 6'(8'd124 - exp_a_reg);
            pf_mask = ~(35'h7FFFFFFFF << rsh);
            pf      = ({2'd0, xr_reg} >> rsh) | {34'd0, |({2'd0, xr_reg} & pf_mask)};
        end
    end

    // round p+0.5 to 24 significant bits, keep the integer part
    always_comb
    begin
        lead = 6'd25;
        for (int i = 25; i < 34; i++)
        begin
            if (sum_reg[i])
            begin
                lead = 6'(i);
            end
        end
        lb    = lead - 6'd23;
        f_low = ~(35'h7FFFFFFFF << lb);
        f_g   = sum_reg[lb - 6'd1];
        f_s   = |(sum_reg & (f_low >> 1));
        f_inc = f_g & (f_s | sum_reg[lb]);
        f_rnd = (sum_reg & ~f_low) + (f_inc ? (35'd1 << lb) : 35'd0);
    end

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        man_a_next = man_a_reg;
        exp_a_next = exp_a_reg;
        man_b_next = man_b_reg;
        exp_b_next = exp_b_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        xr_next    = xr_reg;
        sum_next   = sum_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DONE;
                    res_next   = 32'd0;
                    man_a_next = {1'b1, v_frc};
                    exp_a_next = v_exp;
                    if (mode == MODE_HALF_WIDEN)
                    begin
                        res_next = hpt_widen_half(raw[15:0]);
                    end
                    else if (mode == MODE_HALF_TONE || mode == MODE_FLOAT_TONE)
                    begin
                        if (v_exp == 8'hFF)
                        begin
                            // +inf: alpha saturates, color gives NaN -> 0
                            if (v_frc == 23'd0 && !v_sgn && is_alpha)
                            begin
                                res_next = 32'd255;
                            end
                        end
                        else if (!v_sgn && v_exp >= EXP_TINY)
                        begin
                            if (!is_alpha)
                            begin
                                state_next = S_ADD;
                            end
                            else if (v_exp >= EXP_ONE)
                            begin
                                res_next = 32'd255;
                            end
                            else
                            begin
                                state_next = S_QMUL;
                            end
                        end
                    end
                end
            end
            S_ADD:
            begin
                man_b_next = a_m25[24] ? 24'h800000 : a_m25[23:0];
                exp_b_next = a_m25[24] ? esum + 8'd1 : esum;
                rem_next   = {1'b0, man_a_reg};
                quo_next   = 26'd0;
                cnt_next   = 5'd0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                quo_next = {quo_reg[24:0], d_bit};
                rem_next = {d_rem[23:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                man_a_next = q_m25[24] ? 24'h800000 : q_m25[23:0];
                exp_a_next = q_m25[24] ? 8'(eq + 10'sd1) : eq[7:0];
                if (eq >= 10'sd127 || q_m25[24] && eq >= 10'sd126)
                begin
                    res_next   = 32'd255;
                    state_next = S_DONE;
                end
                else if (eq < 10'sd93)
                begin
                    res_next   = 32'd0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_QMUL;
                end
            end
            S_QMUL:
            begin
                xr_next    = x_prod[31] ? ({8'd0, x_m25} << 8) : ({8'd0, x_m25} << 7);
                state_next = S_QSUM;
            end
            S_QSUM:
            begin
                sum_next   = pf + (35'd1 << 25);
                state_next = S_QFIN;
            end
            S_QFIN:
            begin
                res_next   = {24'd0, f_rnd[33:26]};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        man_a_reg <= man_a_next;
        exp_a_reg <= exp_a_next;
        man_b_reg <= man_b_next;
        exp_b_reg <= exp_b_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        xr_reg    <= xr_next;
        sum_reg   <= sum_next;
    end

    assign stat.busy   = state_reg != S_IDLE;
    assign stat.done   = state_reg == S_DONE;
    assign stat.result = res_reg;

endmodule

[hw/rtl/hpt_merge.sv]
// Merge stage: gathers the four lane results into the output register.
// Depends on hpt_pkg.
module hpt_merge
    import hpt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lane_stat_t                lanes [NUM_LANES],
    input  logic                      out_ready,
    output logic                      take,
    output logic                      out_valid,
    output logic [NUM_LANES*CH_W-1:0] out_data
);

    logic                      valid_reg, valid_next;
    logic [NUM_LANES*CH_W-1:0] data_reg, data_next;
    logic                      all_done;

    always_comb
    begin
        all_done = 1'b1;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            all_done = all_done & lanes[i].done;
        end
        take       = all_done && (!valid_reg || out_ready);
        valid_next = take || (valid_reg && !out_ready);
        data_next  = data_reg;
        if (take)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                data_next[i*CH_W +: CH_W] = lanes[i].result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hw/rtl/hdr_pixel_tonemap_to_unorm8_top.sv]
// HDR pixel converter, top level: RGBA float pixel in, UNORM8 or binary32 pixel out.
// Depends on hpt_pkg, hpt_lane, hpt_merge and the assertion macro header.
//
// One pixel per transaction. Four identical lanes convert R, G, B and A side by side;
// a merge stage collects their results into an output register. source_mode selects
// half -> tonemapped UNORM8 (0), float32 -> tonemapped UNORM8 (1) or half -> float32
// widening (2); mode 3 returns zeros. Tonemapping is v/(1+v) in binary32 RNE followed
// by trunc(t*255+0.5) with the same rounding steps; alpha is only quantized.
// A color channel in the tonemap path goes through the add, the restoring divider that
// produces one quotient bit per cycle (26 steps), the rounding, three quantize steps and
// the merge register; widening, special values and alpha skip the add and the divider,
// and alpha in range runs only the quantize steps. A new pixel is taken once all lanes
// have handed their result to the output register, so the lanes never take a new pixel
// while one is still being converted. The output register can hold a finished pixel while
// the next one is already being worked on. Write source_mode only while idle.
`include "hdr_pixel_tonemap_to_unorm8_top_assert.svh"

module hdr_pixel_tonemap_to_unorm8_top
    import hpt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // config: source_mode
    input  logic         cfg_we,
    input  logic [1:0]   cfg_wdata,
    // input pixel
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // red_in, green_in, blue_in, alpha_in (low first)
    // output pixel
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // red_out, green_out, blue_out, alpha_out (low first)
);

    logic [1:0] source_mode_reg;
    logic       in_xact;
    logic       take;
    logic       any_busy;
    lane_stat_t lanes [NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_mode_reg <= MODE_HALF_TONE;
        end
        else if (cfg_we)
        begin
            source_mode_reg <= cfg_wdata;
        end
    end

    // lanes accept a pixel only when every one of them is free
    always_comb
    begin
        any_busy = 1'b0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            any_busy = any_busy | lanes[i].busy;
        end
    end

    assign s_axis_tready = !any_busy;
    assign in_xact       = s_axis_tvalid && s_axis_tready;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        hpt_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (in_xact),
            .take     (take),
            .mode     (source_mode_reg),
            .is_alpha (g == NUM_LANES - 1),
            .raw      (s_axis_tdata[g*CH_W +: CH_W]),
            .stat     (lanes[g])
        );
    end

    hpt_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lanes     (lanes),
        .out_ready (m_axis_tready),
        .take      (take),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

    // a taken pixel occupies the lanes on the following cycle
    `HPT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_xact, !s_axis_tready, "lanes not busy after accept")
    // lanes 0 and 3 cannot report done while the block is ready for input
    `HPT_ASSERT_IMP(a_idle_no_done, clk, rst_n, s_axis_tready, !(lanes[0].done || lanes[3].done), "done while idle")
    // red and alpha UNORM8 results carry zeros above the low byte
    `HPT_ASSERT_IMP(a_unorm_upper_zero, clk, rst_n, m_axis_tvalid && (source_mode_reg == MODE_HALF_TONE || source_mode_reg == MODE_FLOAT_TONE), m_axis_tdata[31:8] == 24'd0 && m_axis_tdata[127:104] == 24'd0, "unorm8 upper bits set")

endmodule

[tb/hdr_pixel_tonemap_to_unorm8_top_test.sv]
// Testbench for hdr_pixel_tonemap_to_unorm8_top: RGBA pixel stream through all source modes.
// Integer-exact binary32 predictor feeds a small scoreboard class; depends on the DUT
// and hpt_pkg only.
`timescale 1ns / 100ps

module hdr_pixel_tonemap_to_unorm8_top_test;
    import hpt_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // red_in, green_in, blue_in, alpha_in (low first)
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;   // red_out, green_out, blue_out, alpha_out (low first)

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [31:0] F32_ONE    = 32'h3F80_0000;
    localparam int         DRAIN_WAIT  = 60;   // longer than the tonemap path from accept to output valid

    hdr_pixel_tonemap_to_unorm8_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // binary32 arithmetic done on integers, so the prediction never depends
    // on the simulator's own float handling. Positive operands only.
    // ------------------------------------------------------------------

    // value = mant * 2^expo, with the subnormal case folded in
    function automatic void f32_split(input logic [31:0] b, output logic [31:0] mant,
                                      output int expo);
        if (b[30:23] == 8'd0)
        begin
            mant = {9'd0, b[22:0]};
            expo = -149;
        end
        else
        begin
            mant = {8'd0, 1'b1, b[22:0]};
            expo = int'(b[30:23]) - 150;
        end
    endfunction

    // round (m + sticky) * 2^e to nearest even binary32; overflow never arises here
    function automatic logic [31:0] f32_round(input logic [127:0] m, input int e,
                                              input bit sticky);
        int           msb;
        int           biased;
        int           sh;
        logic [127:0] kept;
        bit           half_bit;
        bit           rest;
        msb = 0;
        for (int i = 0; i < 128; i++)
        begin
            if (m[i])
            begin
                msb = i;
            end
        end
        biased = msb + e + 127;
        sh = (biased >= 1) ? msb - 23 : -149 - e;
        if (sh > 0)
        begin
            kept     = m >> sh;
            half_bit = m[sh-1];
            rest     = ((m & ((128'd1 << (sh - 1)) - 1)) != 0) || sticky;
            if (half_bit && (rest || kept[0]))
            begin
                kept = kept + 1;
            end
        end
        else
        begin
            kept = m << (-sh);
        end
        if (biased < 1)
        begin
            // subnormal; a carry into bit 23 lands on the smallest normal by itself
            return kept[31:0];
        end
        if (kept[24])
        begin
            kept   = kept >> 1;
            biased = biased + 1;
        end
        return {1'b0, biased[7:0], kept[22:0]};
    endfunction

    // v + 2^k
    function automatic logic [31:0] f32_add_pow2(input logic [31:0] v, input int k);
        logic [31:0] mv;
        int          ev;
        int          emin;
        f32_split(v, mv, ev);
        if (ev < k - 60)
        begin
            return f32_round(128'd1, k, 1'b0);
        end
        if (ev > k + 40)
        begin
            return v;
        end
        emin = (ev < k) ? ev : k;
        return f32_round((128'(mv) << (ev - emin)) + (128'd1 << (k - emin)), emin, 1'b0);
    endfunction

    function automatic logic [31:0] f32_div(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]  ma;
        logic [31:0]  mb;
        int           ea;
        int           eb;
        logic [127:0] num;
        f32_split(a, ma, ea);
        f32_split(b, mb, eb);
        num = 128'(ma) << 60;
        return f32_round(num / mb, ea - eb - 60, (num % mb) != 0);
    endfunction

    // 0 for non-positive or NaN, 255 from 1.0 up, else trunc(v*255 + 0.5)
    function automatic logic [7:0] unorm8_quant(input logic [31:0] v);
        logic [31:0] r;
        logic [31:0] mr;
        int          er;
        logic [31:0] mv;
        int          ev;
        if (v[31] || v[30:0] == 31'd0 || (v[30:23] == 8'hFF && v[22:0] != 0))
        begin
            return 8'd0;
        end
        if (v >= F32_ONE)
        begin
            return 8'd255;
        end
        f32_split(v, mv, ev);
        r = f32_round(128'(mv) * 255, ev, 1'b0);
        r = f32_add_pow2(r, -1);
        f32_split(r, mr, er);
        return (er < 0) ? 8'(mr >> (-er)) : 8'(mr << er);
    endfunction

    // Reinhard v/(1+v); +inf gives inf/inf = NaN, hence 0
    function automatic logic [7:0] reinhard_unorm8(input logic [31:0] v);
        if (v[31] || v[30:0] == 31'd0 || v[30:23] == 8'hFF)
        begin
            return 8'd0;
        end
        return unorm8_quant(f32_div(v, f32_add_pow2(v, 0)));
    endfunction

    function automatic logic [31:0] half_to_f32(input logic [15:0] h);
        logic [31:0] frac;
        int          ex;
        if (h[14:10] == 5'h1F)
        begin
            return {h[15], 8'hFF, h[9:0], 13'd0};
        end
        if (h[14:10] != 5'd0)
        begin
            return {h[15], 8'(h[14:10] + 8'd112), h[9:0], 13'd0};
        end
        if (h[9:0] == 10'd0)
        begin
            return {h[15], 31'd0};
        end
        // subnormal: shift the leading one up to the hidden position
        frac = {22'd0, h[9:0]};
        ex   = 113;
        while (!frac[10])
        begin
            frac = frac << 1;
            ex   = ex - 1;
        end
        return {h[15], 8'(ex), frac[9:0], 13'd0};
    endfunction

    function automatic logic [127:0] convert_pixel(input logic [127:0] px,
                                                   input logic [1:0] mode);
        logic [127:0] res;
        logic [31:0]  raw;
        logic [31:0]  val;
        res = '0;
        for (int lane = 0; lane < 4; lane++)
        begin
            raw = px[lane*32 +: 32];
            val = (mode == MODE_FLOAT_TONE) ? raw : half_to_f32(raw[15:0]);
            if (mode == MODE_HALF_WIDEN)
            begin
                res[lane*32 +: 32] = val;
            end
            else if (mode == MODE_HALF_TONE || mode == MODE_FLOAT_TONE)
            begin
                // alpha (lane 3) skips the curve
                res[lane*32 +: 8] = (lane == 3) ? unorm8_quant(val) : reinhard_unorm8(val);
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // scoreboard: expected pixels in input order
    // ------------------------------------------------------------------
    class pixel_scoreboard;
        logic [127:0] expected_px[$];
        logic [1:0]   mode;
        int           errors;

        function void note_pixel(logic [127:0] px);
            expected_px.push_back(convert_pixel(px, mode));
        endfunction

        function void check_pixel(logic [127:0] got);
            logic [127:0] want;
            if (expected_px.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output transaction %h", got);
                return;
            end
            want = expected_px.pop_front();
            for (int lane = 0; lane < 4; lane++)
            begin
                if (got[lane*32 +: 32] !== want[lane*32 +: 32])
                begin
                    errors++;
                    if (errors <= 10)
                        $display("lane %0d mismatch: expected %h got %h (pixel exp %h got %h)",
                                 lane, want[lane*32 +: 32], got[lane*32 +: 32], want, got);
                end
            end
        endfunction
    endclass

    pixel_scoreboard sb;
    bit              busy_phase;   // when set, no idling on either side

    // ------------------------------------------------------------------
    // clock, output sampling, receiver stalls
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata);
    end

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (busy_phase || pick < 60)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    int stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left    = stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            stall_left    = idle_len();
            m_axis_tready <= (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // driver tasks; all called at a falling edge
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic [127:0] px);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_pixel(px);
        @(negedge clk);
        gap = idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // hold off until every expected pixel is back, then let the pipe settle
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_px.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic set_mode(input logic [1:0] mode);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        sb.mode   = mode;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] rand_channel(input logic [1:0] mode);
        int          pick;
        logic [31:0] w;
        pick = $urandom_range(0, 9);
        w    = $urandom();
        if (pick < 2)
            return w;                       // raw bits, specials included
        if (mode == MODE_FLOAT_TONE)
        begin
            // mostly moderate exponents where the curve is interesting
            w[30:23] = 8'($urandom_range(100, 140));
            w[31]    = ($urandom_range(0, 9) == 0);
            return w;
        end
        w[14:10] = 5'($urandom_range(0, 30));
        w[15]    = ($urandom_range(0, 9) == 0);
        return w;
    endfunction

    // directed channel values: signed zeros, one, infinities, NaNs, subnormals,
    // max finite, just below one, plus junk in the upper half for half modes
    logic [31:0] corner_vals [0:15] = '{
        32'h0000_0000, 32'h0000_8000, 32'h0000_3C00, 32'h0000_7C00,
        32'h0000_7E01, 32'h0000_FC00, 32'h0000_0001, 32'h0000_03FF,
        32'hFFFF_7BFF, 32'h0000_3BFF, 32'h7F80_0000, 32'h7FC0_0001,
        32'h0000_0001, 32'h7F7F_FFFF, 32'h3F7F_FFFF, 32'hFFFF_0000
    };

    logic [1:0] mode_order [0:3] = '{MODE_HALF_TONE, MODE_FLOAT_TONE, MODE_HALF_WIDEN,
                                     MODE_UNUSED};

    initial
    begin
        logic [127:0] px;
        logic [1:0]   mode;
        int           count;
        sb             = new();
        sb.mode        = MODE_HALF_TONE;
        busy_phase     = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = MODE_HALF_TONE;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: a few corner pixels per mode, mode 0 first from its reset value
        for (int m = 0; m < 4; m++)
        begin
            if (m > 0)
                set_mode(mode_order[m]);
            for (int p = 0; p < 6; p++)
            begin
                for (int lane = 0; lane < 4; lane++)
                    px[lane*32 +: 32] = corner_vals[(p * 4 + lane + m * 3) % 16];
                send_pixel(px);
            end
        end

        // random phases; mode 3 gets less traffic since it only returns zeros
        count = 0;
        while (count < 1200)
        begin
            mode = 2'($urandom_range(0, 3));
            set_mode(mode);
            busy_phase = ($urandom_range(0, 4) == 0);
            for (int n = 0; n < ((mode == MODE_UNUSED) ? 20 : 100); n++)
            begin
                for (int lane = 0; lane < 4; lane++)
                    px[lane*32 +: 32] = rand_channel(mode);
                send_pixel(px);
                count++;
                if (n == 50 && $urandom_range(0, 1) == 0)
                    wait_drain();
            end
            busy_phase = 1'b0;
        end

        wait_drain();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
